// ----- sv/cal_pkg.sv -----
// shared types, constants and calendar functions for the unix time converter
package cal_pkg;

   localparam int unsigned SecWidth    = 32;
   localparam int unsigned DayWidth    = 16;

   localparam logic [SecWidth-1:0] RecipDiv60 = 32'h8888_8889;
   localparam logic [SecWidth-1:0] RecipDiv24 = 32'hAAAA_AAAB;
   localparam logic [SecWidth-1:0] RecipDiv7  = 32'h2492_4925;

   localparam logic [11:0]         SecsPerHour = 12'd3600;
   localparam logic [7:0]          EpochYear   = 8'd70;
   localparam logic [2:0]          EpochWday   = 3'd4;
   localparam logic [3:0]          LastMonth   = 4'd11;

   localparam logic [4:0] ZoneReset = 5'sd3;

   typedef struct packed {
      logic [5:0] sec_of_minute;
      logic [5:0] min_of_hour;
      logic [4:0] hour_of_day;
      logic [2:0] day_of_week;
      logic [4:0] day_of_month;
      logic [3:0] month_of_year;
      logic [7:0] years_since_1900;
   } result_type;

   function automatic logic [8:0] year_len(input logic [7:0] yr);
      logic [8:0] len;
      len = (yr[1:0] != 2'b00) ? 9'd365 : 9'd366;
      return len;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      unique case (mon)
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd30;
         4'd5:    len = 5'd30;
         4'd8:    len = 5'd30;
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ----- sv/cal_cmpsub.sv -----
// shared compare and subtract unit used by the year and month walks
module cal_cmpsub (
   input  logic [cal_pkg::DayWidth-1:0] a,
   input  logic [cal_pkg::DayWidth-1:0] b,
   output logic                         ge,
   output logic [cal_pkg::DayWidth-1:0] diff
);

   logic [cal_pkg::DayWidth:0] wide;

   assign wide = {1'b0, a} - {1'b0, b};
   assign ge   = ~wide[cal_pkg::DayWidth];
   assign diff = wide[cal_pkg::DayWidth-1:0];

endmodule

// ----- sv/cal_seq.sv -----
// sequencer: reciprocal divisions, weekday, year walk and month walk
module cal_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cal_pkg::SecWidth-1:0]  local_secs,
   input  logic                          done_ack,
   output logic                          busy,
   output logic                          done,
   output cal_pkg::result_type           result
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_FIX   = 3'd2;
   localparam logic [2:0] S_YEAR  = 3'd3;
   localparam logic [2:0] S_MONTH = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   localparam logic [1:0] PH_SEC  = 2'd0;
   localparam logic [1:0] PH_MIN  = 2'd1;
   localparam logic [1:0] PH_HOUR = 2'd2;
   localparam logic [1:0] PH_WDAY = 2'd3;

   logic [2:0]                          state_ff, state_in;
   logic [1:0]                          phase_ff, phase_in;
   logic [cal_pkg::SecWidth-1:0]        quo_ff, quo_in;
   logic [cal_pkg::SecWidth-1:0]        prod_ff, prod_in;
   logic [cal_pkg::DayWidth-1:0]        days_ff, days_in;
   logic [7:0]                          yr_ff, yr_in;
   logic [3:0]                          mon_ff, mon_in;
   logic [5:0]                          sec_ff, sec_in;
   logic [5:0]                          min_ff, min_in;
   logic [4:0]                          hr_ff, hr_in;
   logic [2:0]                          wday_ff, wday_in;

   logic [2*cal_pkg::SecWidth-1:0]      mul_full;
   logic [cal_pkg::SecWidth-1:0]        recip;
   logic [cal_pkg::SecWidth-1:0]        quot;
   logic [cal_pkg::SecWidth-1:0]        quot_scaled;
   logic [cal_pkg::SecWidth-1:0]        remain;
   logic [cal_pkg::DayWidth-1:0]        unit_a, unit_b, unit_diff;
   logic                                unit_ge;

   cal_cmpsub u_unit (
      .a    (unit_a),
      .b    (unit_b),
      .ge   (unit_ge),
      .diff (unit_diff)
   );

   // quotient is the high product word shifted right by the per-divisor amount
   always_comb begin
      unique case (phase_ff)
         PH_SEC: begin
            recip = cal_pkg::RecipDiv60;
            quot  = {5'd0, prod_ff[cal_pkg::SecWidth-1:5]};
         end
         PH_MIN: begin
            recip = cal_pkg::RecipDiv60;
            quot  = {5'd0, prod_ff[cal_pkg::SecWidth-1:5]};
         end
         PH_HOUR: begin
            recip = cal_pkg::RecipDiv24;
            quot  = {4'd0, prod_ff[cal_pkg::SecWidth-1:4]};
         end
         default: begin
            recip = cal_pkg::RecipDiv7;
            quot  = prod_ff;
         end
      endcase
   end

   always_comb begin
      unique case (phase_ff)
         PH_SEC:  quot_scaled = {quot[25:0], 6'd0} - {quot[29:0], 2'd0};
         PH_MIN:  quot_scaled = {quot[25:0], 6'd0} - {quot[29:0], 2'd0};
         PH_HOUR: quot_scaled = {quot[27:0], 4'd0} + {quot[28:0], 3'd0};
         default: quot_scaled = {quot[28:0], 3'd0} - quot;
      endcase
   end

   assign mul_full = {{cal_pkg::SecWidth{1'b0}}, quo_ff} * {{cal_pkg::SecWidth{1'b0}}, recip};
   assign remain   = quo_ff - quot_scaled;

   always_comb begin
      unique case (state_ff)
         S_YEAR: begin
            unit_a = days_ff;
            unit_b = {7'd0, cal_pkg::year_len(yr_ff)};
         end
         S_MONTH: begin
            unit_a = days_ff;
            unit_b = {11'd0, cal_pkg::month_len(mon_ff, (yr_ff[1:0] == 2'b00))};
         end
         default: begin
            unit_a = '0;
            unit_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      quo_in   = quo_ff;
      prod_in  = prod_ff;
      days_in  = days_ff;
      yr_in    = yr_ff;
      mon_in   = mon_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hr_in    = hr_ff;
      wday_in  = wday_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_MUL;
               phase_in = PH_SEC;
               quo_in   = local_secs;
            end
         end
         S_MUL: begin
            prod_in  = mul_full[2*cal_pkg::SecWidth-1:cal_pkg::SecWidth];
            state_in = S_FIX;
         end
         S_FIX: begin
            phase_in = phase_ff + 2'd1;
            quo_in   = quot;
            state_in = S_MUL;
            unique case (phase_ff)
               PH_SEC:  sec_in = remain[5:0];
               PH_MIN:  min_in = remain[5:0];
               PH_HOUR: begin
                  hr_in   = remain[4:0];
                  days_in = quot[cal_pkg::DayWidth-1:0];
                  quo_in  = {{(cal_pkg::SecWidth-cal_pkg::DayWidth){1'b0}},
                             quot[cal_pkg::DayWidth-1:0]}
                            + {{(cal_pkg::SecWidth-3){1'b0}}, cal_pkg::EpochWday};
               end
               default: begin
                  wday_in  = remain[2:0];
                  yr_in    = cal_pkg::EpochYear;
                  state_in = S_YEAR;
               end
            endcase
         end
         S_YEAR: begin
            if (unit_ge) begin
               days_in = unit_diff;
               yr_in   = yr_ff + 8'd1;
            end else begin
               mon_in   = '0;
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            if (unit_ge) begin
               days_in = unit_diff;
               if (mon_ff == cal_pkg::LastMonth) begin
                  state_in = S_DONE;
               end else begin
                  mon_in = mon_ff + 4'd1;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (done_ack) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_SEC;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      prod_ff <= prod_in;
      days_ff <= days_in;
      yr_ff   <= yr_in;
      mon_ff  <= mon_in;
      sec_ff  <= sec_in;
      min_ff  <= min_in;
      hr_ff   <= hr_in;
      wday_ff <= wday_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);

   assign result.sec_of_minute    = sec_ff;
   assign result.min_of_hour      = min_ff;
   assign result.hour_of_day      = hr_ff;
   assign result.day_of_week      = wday_ff;
   assign result.day_of_month     = days_ff[4:0] + 5'd1;
   assign result.month_of_year    = mon_ff + 4'd1;
   assign result.years_since_1900 = yr_ff;

endmodule

// ----- sv/unix_seconds_to_calendar_core.sv -----
// Converts a 32-bit unix second count, shifted by a signed whole-hour zone offset
// (csr register 0, reset +3, applied modulo 2^32), to local second, minute, hour,
// weekday (0 Sunday), day of month, month (1..12) and years since 1900, using the
// every-fourth-year leap rule. Four constant divisions by reciprocal multiplication run in
// turn on one shared multiplier, each as a multiply state and a fix state; then the year
// walk (years walked from 1970: 0..136) and the month walk (months examined: 1..12) run
// one step a cycle through a single 16-bit compare-and-subtract unit. The request side
// stalls for the whole conversion; the result sits in an output register and the next
// request is taken the cycle after it has been moved there, so no request is taken while
// a conversion is in progress.
module unix_seconds_to_calendar_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_sec_of_minute,
   output logic [5:0]  rsp_min_of_hour,
   output logic [4:0]  rsp_hour_of_day,
   output logic [2:0]  rsp_day_of_week,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month_of_year,
   output logic [7:0]  rsp_years_since_1900,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [4:0]                   zone_ff, zone_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   cal_pkg::result_type          rsp_data_ff, rsp_data_in;
   logic [cal_pkg::SecWidth-1:0] zone_secs;
   logic [cal_pkg::SecWidth-1:0] local_secs;
   logic                         start;
   logic                         seq_busy;
   logic                         seq_done;
   logic                         load;
   cal_pkg::result_type          seq_result;

   assign pready = 1'b1;
   assign prdata = {27'd0, zone_ff};

   always_comb begin
      zone_in = zone_ff;
      if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
         zone_in = pwdata[4:0];
      end
   end

   assign zone_secs  = {{(cal_pkg::SecWidth-5){zone_ff[4]}}, zone_ff}
                       * {{(cal_pkg::SecWidth-12){1'b0}}, cal_pkg::SecsPerHour};
   assign local_secs = req_epoch_seconds + zone_secs;

   assign req_stall = seq_busy;
   assign start     = req_valid && !seq_busy;

   cal_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .local_secs (local_secs),
      .done_ack   (load),
      .busy       (seq_busy),
      .done       (seq_done),
      .result     (seq_result)
   );

   assign load = seq_done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff      <= cal_pkg::ZoneReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         zone_ff      <= zone_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sec_of_minute    = rsp_data_ff.sec_of_minute;
   assign rsp_min_of_hour      = rsp_data_ff.min_of_hour;
   assign rsp_hour_of_day      = rsp_data_ff.hour_of_day;
   assign rsp_day_of_week      = rsp_data_ff.day_of_week;
   assign rsp_day_of_month     = rsp_data_ff.day_of_month;
   assign rsp_month_of_year    = rsp_data_ff.month_of_year;
   assign rsp_years_since_1900 = rsp_data_ff.years_since_1900;

endmodule

// ----- sv/cal_core_checker.sv -----
// port-level checker for the unix time converter and its bind
module cal_core_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [5:0]  rsp_sec_of_minute,
   input logic [5:0]  rsp_min_of_hour,
   input logic [4:0]  rsp_hour_of_day,
   input logic [2:0]  rsp_day_of_week,
   input logic [4:0]  rsp_day_of_month,
   input logic [3:0]  rsp_month_of_year
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a request transfer starts a conversion that stalls the request side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side not stalled after transfer");

   // fields of an offered result are in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sec_of_minute < 6'd60) && (rsp_min_of_hour < 6'd60)
                 && (rsp_hour_of_day < 5'd24) && (rsp_day_of_week < 3'd7)
                 && (rsp_day_of_month != 5'd0) && (rsp_month_of_year != 4'd0)
                 && (rsp_month_of_year < 4'd13))
      else $error("result field out of range");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind unix_seconds_to_calendar_core cal_core_checker u_cal_core_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_sec_of_minute (rsp_sec_of_minute),
   .rsp_min_of_hour   (rsp_min_of_hour),
   .rsp_hour_of_day   (rsp_hour_of_day),
   .rsp_day_of_week   (rsp_day_of_week),
   .rsp_day_of_month  (rsp_day_of_month),
   .rsp_month_of_year (rsp_month_of_year)
);

// ----- test/unix_seconds_to_calendar_core_tb.sv -----
// self-checking testbench for the unix seconds to local calendar converter
`timescale 1ns / 1ps

module unix_seconds_to_calendar_core_tb;

   localparam logic [2:0] ZoneAddr      = 3'd0;
   localparam int         HoldCycles    = 1500;
   localparam int         QuietLimit    = 20000;
   localparam int         SettleCycles  = 300;
   localparam int         ItemsPerPhase = 150;
   localparam int         PhaseCount    = 6;

   typedef struct {
      logic [4:0]          zone;
      logic [31:0]         epoch;
      bit                  known;
      cal_pkg::result_type want;
   } calendar_case_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_epoch_seconds;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_sec_of_minute;
   logic [5:0]  rsp_min_of_hour;
   logic [4:0]  rsp_hour_of_day;
   logic [2:0]  rsp_day_of_week;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month_of_year;
   logic [7:0]  rsp_years_since_1900;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   bit                  offer_known;
   cal_pkg::result_type offer_want;
   logic [4:0]          zone_setting = cal_pkg::ZoneReset;
   cal_pkg::result_type calendar_queue[$];
   calendar_case_type   calendar_cases[$];
   int                  failures = 0;
   int                  req_idle_pct = 20;
   int                  rsp_idle_pct = 20;
   bit                  hold_off_request = 1'b0;

   unix_seconds_to_calendar_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_sec_of_minute    (rsp_sec_of_minute),
      .rsp_min_of_hour      (rsp_min_of_hour),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_day_of_week      (rsp_day_of_week),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_month_of_year    (rsp_month_of_year),
      .rsp_years_since_1900 (rsp_years_since_1900),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic cal_pkg::result_type to_local_calendar(input logic [31:0] epoch,
                                                             input logic [4:0]  zone);
      logic [31:0] shifted;
      logic [31:0] mins;
      logic [31:0] hours;
      logic [31:0] days;
      logic [31:0] used;
      logic [31:0] left;
      logic [31:0] span;
      logic [7:0]  yr;
      logic [3:0]  mon;
      logic [4:0]  mlen;
      bit          walking;
      cal_pkg::result_type r;
      shifted = epoch + {{27{zone[4]}}, zone} * 32'd3600;
      r.sec_of_minute = 6'(shifted % 32'd60);
      mins = shifted / 32'd60;
      r.min_of_hour = 6'(mins % 32'd60);
      hours = mins / 32'd60;
      r.hour_of_day = 5'(hours % 32'd24);
      days = hours / 32'd24;
      r.day_of_week = 3'((days + 32'd4) % 32'd7);
      yr = 8'd70;
      used = 32'd0;
      span = 32'd366;
      walking = 1'b1;
      while (walking) begin
         span = (yr[1:0] == 2'b00) ? 32'd366 : 32'd365;
         if (used + span <= days) begin
            used = used + span;
            yr = yr + 8'd1;
         end else begin
            walking = 1'b0;
         end
      end
      left = days - used;
      mon = 4'd0;
      walking = 1'b1;
      while (walking && mon < 4'd11) begin
         unique case (mon)
            4'd1:    mlen = (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd3,
            4'd5,
            4'd8,
            4'd10:   mlen = 5'd30;
            default: mlen = 5'd31;
         endcase
         if (left >= 32'(mlen)) begin
            left = left - 32'(mlen);
            mon = mon + 4'd1;
         end else begin
            walking = 1'b0;
         end
      end
      r.day_of_month = 5'(left + 32'd1);
      r.month_of_year = mon + 4'd1;
      r.years_since_1900 = yr;
      return r;
   endfunction

   function automatic logic [31:0] year_start_day(input int yr);
      logic [31:0] d;
      d = 32'd0;
      for (int y = 70; y < yr; y++) begin
         d = d + (((y % 4) == 0) ? 32'd366 : 32'd365);
      end
      return d;
   endfunction

   function automatic logic [31:0] pick_epoch();
      logic [31:0] day;
      int          yr;
      yr = $urandom_range(206, 71);
      unique case ($urandom_range(9))
         0:       return 32'($urandom_range(200000));
         1:       return 32'hFFFF_FFFF - 32'($urandom_range(200000));
         2, 3: begin
            day = year_start_day(yr) - 32'd1 + 32'($urandom_range(1));
            return day * 32'd86400 + 32'($urandom_range(86399));
         end
         4: begin
            day = year_start_day(yr) + 32'($urandom_range(60, 57));
            return day * 32'd86400 + 32'($urandom_range(86399));
         end
         default: return $urandom();
      endcase
   endfunction

   function automatic void add_case(input logic [4:0] zone, input logic [31:0] epoch,
                                    input bit known, input cal_pkg::result_type want);
      calendar_case_type c;
      c.zone = zone;
      c.epoch = epoch;
      c.known = known;
      c.want = want;
      calendar_cases.push_back(c);
   endfunction

   task automatic offer_epoch(input logic [31:0] epoch, input bit known,
                              input cal_pkg::result_type want);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= epoch;
      offer_known <= known;
      offer_want <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (calendar_queue.size() != 0) @(posedge clock);
   endtask

   task automatic reconfigure(input logic [4:0] zone);
      wait_for_results();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ZoneAddr;
      pwdata <= {27'($urandom()), zone};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      zone_setting = zone;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[4:0] !== zone) begin
         $error("zone_offset_hours: expected %0d, got %0d", zone, prdata[4:0]);
         failures++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // expectations are queued at each request transfer, checked at each result transfer
   always @(posedge clock) begin : transfer_monitor
      cal_pkg::result_type want;
      if (!reset && req_valid && !req_stall) begin
         calendar_queue.push_back(offer_known ? offer_want :
                                  to_local_calendar(req_epoch_seconds, zone_setting));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (calendar_queue.size() == 0) begin
            $error("result transfer with no conversion outstanding");
            failures++;
         end else begin
            want = calendar_queue.pop_front();
            if (rsp_sec_of_minute !== want.sec_of_minute) begin
               $error("sec_of_minute: expected %0d, got %0d",
                      want.sec_of_minute, rsp_sec_of_minute);
               failures++;
            end
            if (rsp_min_of_hour !== want.min_of_hour) begin
               $error("min_of_hour: expected %0d, got %0d", want.min_of_hour, rsp_min_of_hour);
               failures++;
            end
            if (rsp_hour_of_day !== want.hour_of_day) begin
               $error("hour_of_day: expected %0d, got %0d", want.hour_of_day, rsp_hour_of_day);
               failures++;
            end
            if (rsp_day_of_week !== want.day_of_week) begin
               $error("day_of_week: expected %0d, got %0d", want.day_of_week, rsp_day_of_week);
               failures++;
            end
            if (rsp_day_of_month !== want.day_of_month) begin
               $error("day_of_month: expected %0d, got %0d",
                      want.day_of_month, rsp_day_of_month);
               failures++;
            end
            if (rsp_month_of_year !== want.month_of_year) begin
               $error("month_of_year: expected %0d, got %0d",
                      want.month_of_year, rsp_month_of_year);
               failures++;
            end
            if (rsp_years_since_1900 !== want.years_since_1900) begin
               $error("years_since_1900: expected %0d, got %0d",
                      want.years_since_1900, rsp_years_since_1900);
               failures++;
            end
         end
      end
   end

   initial begin : result_stall_driver
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            for (n = 0; n < HoldCycles; n++) @(posedge clock);
            hold_off_request = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      logic [4:0]  zone;
      logic [31:0] leap_day;
      int          phase;
      int          n;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_epoch_seconds <= 32'd0;
      offer_known <= 1'b0;
      offer_want <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ZoneAddr;
      pwdata <= 32'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first row runs on the offset left by reset
      leap_day = year_start_day(200) + 32'd59;
      add_case(5'd3, 32'd0, 1'b1, {6'd0, 6'd0, 5'd3, 3'd4, 5'd1, 4'd1, 8'd70});
      add_case(5'd3, 32'hFFFF_FFFF, 1'b0, '0);
      add_case(5'd0, 32'd0, 1'b1, {6'd0, 6'd0, 5'd0, 3'd4, 5'd1, 4'd1, 8'd70});
      add_case(5'd0, 32'd86399, 1'b1, {6'd59, 6'd59, 5'd23, 3'd4, 5'd1, 4'd1, 8'd70});
      add_case(5'd0, 32'd31535999, 1'b1, {6'd59, 6'd59, 5'd23, 3'd4, 5'd31, 4'd12, 8'd70});
      add_case(5'd0, 32'd951782400, 1'b1, {6'd0, 6'd0, 5'd0, 3'd2, 5'd29, 4'd2, 8'd100});
      add_case(5'd0, 32'hFFFF_FFFF, 1'b0, '0);
      add_case(5'd0, 32'h8000_0000, 1'b0, '0);
      add_case(5'd0, 32'h7FFF_FFFF, 1'b0, '0);
      add_case(5'd0, 32'h5555_5555, 1'b0, '0);
      add_case(5'd0, 32'hAAAA_AAAA, 1'b0, '0);
      add_case(5'd0, year_start_day(200) * 32'd86400 - 32'd1, 1'b0, '0);
      add_case(5'd0, leap_day * 32'd86400 - 32'd1, 1'b0, '0);
      add_case(5'd0, leap_day * 32'd86400, 1'b0, '0);
      add_case(5'd0, (leap_day + 32'd1) * 32'd86400, 1'b0, '0);
      add_case(-5'sd1, 32'd0, 1'b0, '0);
      add_case(-5'sd12, 32'd43199, 1'b0, '0);
      add_case(5'b10000, 32'd0, 1'b0, '0);
      add_case(5'b10000, 32'd57599, 1'b0, '0);
      add_case(5'b10000, 32'd57600, 1'b1, {6'd0, 6'd0, 5'd0, 3'd4, 5'd1, 4'd1, 8'd70});
      add_case(5'd15, 32'hFFFF_FFFF, 1'b0, '0);
      add_case(5'd15, 32'd4294913296, 1'b1, {6'd0, 6'd0, 5'd0, 3'd4, 5'd1, 4'd1, 8'd70});
      add_case(5'd14, 32'd0, 1'b1, {6'd0, 6'd0, 5'd14, 3'd4, 5'd1, 4'd1, 8'd70});
      add_case(5'd14, 32'hFFFF_FFFF - 32'd50400, 1'b0, '0);

      foreach (calendar_cases[i]) begin
         if (calendar_cases[i].zone != zone_setting) begin
            reconfigure(calendar_cases[i].zone);
         end
         offer_epoch(calendar_cases[i].epoch, calendar_cases[i].known, calendar_cases[i].want);
      end

      for (phase = 0; phase < PhaseCount; phase++) begin
         unique case (phase)
            0:       zone = -5'sd12;
            1:       zone = 5'd14;
            2:       zone = 5'b10000;
            3:       zone = 5'd15;
            4:       zone = 5'($urandom_range(31));
            default: zone = 5'd3;
         endcase
         reconfigure(zone);
         req_idle_pct = (phase == 2) ? 0 : 20;
         rsp_idle_pct = (phase == 2) ? 0 : 20;
         for (n = 0; n < ItemsPerPhase; n++) begin
            if (phase == 1 && n == 40) hold_off_request = 1'b1;
            if (phase == 3 && n == 75) wait_for_results();
            offer_epoch(pick_epoch(), 1'b0, '0);
         end
      end

      wait_for_results();
      repeat (SettleCycles) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
